FILE: design/atc_pkg.sv
// Shared types and constants for the ANSI text console parser.
// Used by atc_core, atc_queue and the top level; depends on nothing.
package atc_pkg;

  typedef enum logic [2:0] {
    CMD_GLYPH  = 3'd0,
    CMD_CLEOL  = 3'd1,
    CMD_CLS    = 3'd2,
    CMD_SCROLL = 3'd3,
    CMD_BEEP   = 3'd4
  } cmd_t;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] REG_TAB_SHIFT    = 2'd2;

  localparam logic [11:0] SCREEN_WIDTH_RST = 12'd800;
  localparam logic [7:0]  ROW_COUNT_RST    = 8'd37;
  localparam logic [2:0]  TAB_SHIFT_RST    = 3'd5;

  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;
  localparam logic [7:0] CH_FINAL_K  = 8'h4B;
  localparam logic [7:0] CH_FINAL_G  = 8'h47;
  localparam logic [7:0] CH_FINAL_M  = 8'h6D;

  localparam logic [7:0] SGR_RESET       = 8'd0;
  localparam logic [7:0] SGR_BOLD        = 8'd1;
  localparam logic [7:0] SGR_UNDERLINE   = 8'd4;
  localparam logic [7:0] SGR_REVERSE     = 8'd7;
  localparam logic [7:0] SGR_NO_BOLD     = 8'd21;
  localparam logic [7:0] SGR_NO_UNDERLN  = 8'd24;
  localparam logic [7:0] SGR_NO_REVERSE  = 8'd27;
  localparam logic [7:0] SGR_FG_FIRST    = 8'd30;
  localparam logic [7:0] SGR_FG_LAST     = 8'd37;
  localparam logic [7:0] SGR_BG_FIRST    = 8'd40;
  localparam logic [7:0] SGR_BG_LAST     = 8'd47;

  localparam logic [3:0] FORE_RST = 4'd0;
  localparam logic [3:0] BACK_RST = 4'd15;

  localparam logic [11:0] POS_MAX = 12'hFFF;

  typedef struct packed {
    cmd_t        command;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  glyph;
    logic [3:0]  fore_index;
    logic [3:0]  back_index;
    logic        bold_on;
    logic        underline_on;
    logic        reverse_on;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [3:0] ansi_to_vga(input logic [2:0] code);
    logic [3:0] vga;
    unique case (code)
      3'd0: vga = 4'd0;
      3'd1: vga = 4'd4;
      3'd2: vga = 4'd2;
      3'd3: vga = 4'd6;
      3'd4: vga = 4'd1;
      3'd5: vga = 4'd5;
      3'd6: vga = 4'd3;
      3'd7: vga = 4'd7;
      default: vga = 4'd0;
    endcase
    return vga;
  endfunction

  function automatic result_t make_result(input cmd_t cmd, input logic [11:0] x,
                                          input logic [11:0] y);
    result_t r;
    r = '0;
    r.command = cmd;
    r.pos_x = x;
    r.pos_y = y;
    return r;
  endfunction

endpackage

FILE: design/atc_if.sv
// Channel interfaces of the ANSI text console parser: byte input and command output.
// No dependencies.
interface atc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface atc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  glyph;
  logic [3:0]  fore_index;
  logic [3:0]  back_index;
  logic        bold_on;
  logic        underline_on;
  logic        reverse_on;
  logic        last_of_run;

  modport source (output valid, output command, output pos_x, output pos_y,
                  output glyph, output fore_index, output back_index,
                  output bold_on, output underline_on, output reverse_on,
                  output last_of_run, input ready);
  modport sink (input valid, input command, input pos_x, input pos_y,
                input glyph, input fore_index, input back_index,
                input bold_on, input underline_on, input reverse_on,
                input last_of_run, output ready);
endinterface

FILE: design/atc_core.sv
// Input register, configuration registers, parser/cursor state and command decode.
// Depends on atc_pkg; pushes up to two commands per word into atc_queue.
module atc_core #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic                in_valid,
  input  logic [7:0]          in_char,
  output logic                in_ready,
  input  logic                room,
  output atc_pkg::push_t      push
);
  import atc_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_CSI   = 2'd2
  } mode_t;

  logic [11:0] screen_width;
  logic [7:0]  row_count;
  logic [2:0]  tab_shift;

  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        fire;

  mode_t       mode, mode_next;
  logic [7:0]  csi_number, csi_number_next;
  logic [11:0] cursor_col, cursor_col_next;
  logic [11:0] cursor_row, cursor_row_next;
  logic        bold_flag, bold_flag_next;
  logic        underline_flag, underline_flag_next;
  logic        reverse_flag, reverse_flag_next;
  logic [3:0]  fore_color, fore_color_next;
  logic [3:0]  back_color, back_color_next;

  logic        csi_digit;
  logic [11:0] csi_acc;
  logic [7:0]  csi_sat;
  logic [11:0] col_from_csi;
  logic [12:0] tab_step;
  logic [12:0] tab_sum;
  logic [12:0] tab_stop;
  logic [11:0] tab_col;
  logic [14:0] row_limit;
  logic [12:0] row_adv;
  logic        row_fits;
  logic [11:0] row_after_nl;
  logic [12:0] col_adv;
  logic        wrap;
  logic [11:0] glyph_col;
  logic [11:0] glyph_row;
  logic [12:0] glyph_end;
  logic [7:0]  fg_off;
  logic [7:0]  bg_off;
  logic        plain;
  result_t     glyph_res;

  assign fire     = byte_valid && room;
  assign in_ready = !byte_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SCREEN_WIDTH_RST;
      row_count    <= ROW_COUNT_RST;
      tab_shift    <= TAB_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH: screen_width <= cfg_data;
        REG_ROW_COUNT:    row_count    <= cfg_data[7:0];
        REG_TAB_SHIFT:    tab_shift    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (fire) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_PLAIN;
      csi_number     <= '0;
      cursor_col     <= '0;
      cursor_row     <= '0;
      bold_flag      <= 1'b0;
      underline_flag <= 1'b0;
      reverse_flag   <= 1'b0;
      fore_color     <= FORE_RST;
      back_color     <= BACK_RST;
    end else begin
      mode           <= mode_next;
      csi_number     <= csi_number_next;
      cursor_col     <= cursor_col_next;
      cursor_row     <= cursor_row_next;
      bold_flag      <= bold_flag_next;
      underline_flag <= underline_flag_next;
      reverse_flag   <= reverse_flag_next;
      fore_color     <= fore_color_next;
      back_color     <= back_color_next;
    end
  end

  assign csi_digit    = (byte_q >= CH_DIGIT0) && (byte_q <= CH_DIGIT9);
  assign csi_acc      = {4'd0, csi_number} * 12'd10 + {4'd0, 8'(byte_q - CH_DIGIT0)};
  assign csi_sat      = (csi_acc > 12'd255) ? 8'd255 : csi_acc[7:0];
  assign col_from_csi = 12'({12'd0, csi_number} * 20'(GLYPH_WIDTH));

  assign tab_step = 13'd1 << tab_shift;
  assign tab_sum  = {1'b0, cursor_col} + tab_step;
  assign tab_stop = tab_sum & ~(tab_step - 13'd1);
  assign tab_col  = tab_stop[12] ? POS_MAX : tab_stop[11:0];

  assign row_limit    = 15'(8'(row_count - 8'd1)) * 15'(GLYPH_HEIGHT);
  assign row_adv      = {1'b0, cursor_row} + 13'(GLYPH_HEIGHT);
  assign row_fits     = (row_count != 8'd0) && ({3'd0, cursor_row} < row_limit)
                        && (row_adv <= {1'b0, POS_MAX});
  assign row_after_nl = row_fits ? row_adv[11:0] : cursor_row;

  assign col_adv   = {1'b0, cursor_col} + 13'(GLYPH_WIDTH);
  assign wrap      = col_adv >= {1'b0, screen_width};
  assign glyph_col = wrap ? 12'd0 : cursor_col;
  assign glyph_row = wrap ? row_after_nl : cursor_row;
  assign glyph_end = {1'b0, glyph_col} + 13'(GLYPH_WIDTH);

  assign fg_off = csi_number - SGR_FG_FIRST;
  assign bg_off = csi_number - SGR_BG_FIRST;

  always_comb begin
    glyph_res              = make_result(CMD_GLYPH, glyph_col, glyph_row);
    glyph_res.glyph        = byte_q;
    glyph_res.fore_index   = fore_color;
    glyph_res.back_index   = back_color;
    glyph_res.bold_on      = bold_flag;
    glyph_res.underline_on = underline_flag;
    glyph_res.reverse_on   = reverse_flag;
  end

  always_comb begin
    mode_next           = mode;
    csi_number_next     = csi_number;
    cursor_col_next     = cursor_col;
    cursor_row_next     = cursor_row;
    bold_flag_next      = bold_flag;
    underline_flag_next = underline_flag;
    reverse_flag_next   = reverse_flag;
    fore_color_next     = fore_color;
    back_color_next     = back_color;
    push                = '0;
    plain               = 1'b0;

    if (fire && (byte_q != 8'd0)) begin
      unique case (mode)
        MODE_ESC: begin
          if (byte_q == CH_LBRACKET) begin
            mode_next       = MODE_CSI;
            csi_number_next = '0;
          end else begin
            mode_next = MODE_PLAIN;
            plain     = 1'b1;
          end
        end
        MODE_CSI: begin
          if (csi_digit) begin
            csi_number_next = csi_sat;
          end else begin
            mode_next = MODE_PLAIN;
            priority if (byte_q == CH_FINAL_K) begin
              push.count = 2'd1;
              push.first = make_result(CMD_CLEOL, cursor_col, cursor_row);
            end else if (byte_q == CH_FINAL_G) begin
              cursor_col_next = col_from_csi;
            end else if (byte_q == CH_FINAL_M) begin
              priority if (csi_number == SGR_RESET) begin
                bold_flag_next      = 1'b0;
                underline_flag_next = 1'b0;
                reverse_flag_next   = 1'b0;
                fore_color_next     = FORE_RST;
                back_color_next     = BACK_RST;
              end else if (csi_number == SGR_BOLD) begin
                bold_flag_next = 1'b1;
              end else if (csi_number == SGR_UNDERLINE) begin
                underline_flag_next = 1'b1;
              end else if (csi_number == SGR_REVERSE) begin
                reverse_flag_next = 1'b1;
              end else if (csi_number == SGR_NO_BOLD) begin
                bold_flag_next = 1'b0;
              end else if (csi_number == SGR_NO_UNDERLN) begin
                underline_flag_next = 1'b0;
              end else if (csi_number == SGR_NO_REVERSE) begin
                reverse_flag_next = 1'b0;
              end else if (csi_number >= SGR_FG_FIRST && csi_number <= SGR_FG_LAST) begin
                fore_color_next = ansi_to_vga(fg_off[2:0]);
              end else if (csi_number >= SGR_BG_FIRST && csi_number <= SGR_BG_LAST) begin
                back_color_next = ansi_to_vga(bg_off[2:0]);
              end else begin
              end
            end else begin
            end
          end
        end
        default: begin
          mode_next = MODE_PLAIN;
          plain     = 1'b1;
        end
      endcase

      if (plain) begin
        unique case (byte_q)
          CH_BEL: begin
            push.count = 2'd1;
            push.first = make_result(CMD_BEEP, 12'd0, 12'd0);
          end
          CH_TAB: begin
            cursor_col_next = tab_col;
          end
          CH_FF: begin
            cursor_col_next = '0;
            cursor_row_next = '0;
            push.count      = 2'd1;
            push.first      = make_result(CMD_CLS, 12'd0, 12'd0);
          end
          CH_ESC: begin
            mode_next = MODE_ESC;
          end
          CH_LF: begin
            cursor_col_next = '0;
            cursor_row_next = row_after_nl;
            if (!row_fits) begin
              push.count = 2'd1;
              push.first = make_result(CMD_SCROLL, 12'd0, cursor_row);
            end
          end
          CH_CR: begin
            cursor_col_next = '0;
            push.count      = 2'd1;
            push.first      = make_result(CMD_CLEOL, 12'd0, cursor_row);
          end
          default: begin
            cursor_row_next = glyph_row;
            cursor_col_next = glyph_end[12] ? POS_MAX : glyph_end[11:0];
            if (wrap && !row_fits) begin
              push.count  = 2'd2;
              push.first  = make_result(CMD_SCROLL, 12'd0, cursor_row);
              push.second = glyph_res;
            end else begin
              push.count = 2'd1;
              push.first = glyph_res;
            end
          end
        endcase
      end

      if (push.count == 2'd1) begin
        push.first.last_of_run = 1'b1;
      end else if (push.count == 2'd2) begin
        push.second.last_of_run = 1'b1;
      end
    end
  end

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.command == CMD_SCROLL
                           && push.second.command == CMD_GLYPH)
    else $error("two-command word not scroll then glyph");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
    else $error("last_of_run misplaced on two-command word");

  a_csi_enter: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == MODE_ESC && byte_q == CH_LBRACKET)
      |=> (mode == MODE_CSI && csi_number == 8'd0))
    else $error("ESC [ did not enter CSI with cleared parameter");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |-> push.count == 2'd0)
    else $error("command pushed without a word in process");

endmodule

FILE: design/atc_queue.sv
// Four-entry result queue: takes up to two commands a cycle while room is high,
// drains one a cycle while out_ch is ready. Depends on atc_pkg and atc_if.
module atc_queue (
  input  logic           clk,
  input  logic           rst,
  input  atc_pkg::push_t push,
  output logic           room,
  atc_out_if.source      out_ch
);
  import atc_pkg::*;

  localparam int DEPTH = 4;

  result_t     entries [DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        pop;
  result_t     head;

  assign room = count <= 3'(DEPTH - 2);
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

  assign out_ch.valid        = count != 3'd0;
  assign out_ch.command      = head.command;
  assign out_ch.pos_x        = head.pos_x;
  assign out_ch.pos_y        = head.pos_y;
  assign out_ch.glyph        = head.glyph;
  assign out_ch.fore_index   = head.fore_index;
  assign out_ch.back_index   = head.back_index;
  assign out_ch.bold_on      = head.bold_on;
  assign out_ch.underline_on = head.underline_on;
  assign out_ch.reverse_on   = head.reverse_on;
  assign out_ch.last_of_run  = head.last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - 3'd1)
    else $error("queue count did not drop on drain");

endmodule

FILE: design/ansi_text_console_parser.sv
// Top level of the ANSI text console parser: byte stream in, drawing commands out.
// Depends on atc_pkg, atc_if, atc_core and atc_queue.
//
//   channel   dir  word                                   handshake
//   in_ch     in   char_code[7:0]                         valid/ready
//   out_ch    out  command, pos_x/y, glyph, colors, attrs valid/ready
//   cfg       in   cfg_index[1:0], cfg_data[11:0]         cfg_we, no wait
//
// One byte a cycle while the queue has room: a word is held in the input
// register, is decoded and pushes its 0..2 commands into a 4-entry queue
// that drains one a cycle while out_ch is ready. A byte that wraps with a
// scroll yields two commands. Input is taken while the input register is
// empty or the queue has two free entries.
// rst is synchronous: cursor, parser, attributes, queue and config registers.
module ansi_text_console_parser #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  atc_in_if.sink      in_ch,
  atc_out_if.source   out_ch
);
  import atc_pkg::*;

  push_t push;
  logic  room;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  atc_core #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_char   (in_ch.char_code),
    .in_ready  (in_ready),
    .room      (room),
    .push      (push)
  );

  atc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
